// ===== hw/rtl/blfr_pkg.sv =====
// ----------------------------------------------------------------------------
// blfr_pkg
// shared types, codes and the byte-wise crc-32 step of the frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package blfr_pkg;

    // default frame size limit, crc bytes included
    localparam int MAX_FRAME_BYTES_DEF = 16384;

    // fixed field widths
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 14;
    localparam int MID_W   = 16;
    localparam int MTYPE_W = 2;
    localparam int CRC_W   = 32;
    localparam int TOT_W   = 17;   // payload length + header length, full range
    localparam int CFG_IDX_W = 3;

    // register reset values
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h44;
    localparam logic [7:0]  SYNC_THIRD_RST  = 8'h12;
    localparam logic [7:0]  HDR_LEN_RST     = 8'd28;
    localparam logic [31:0] CRC_POLY_RST    = 32'hEDB88320;

    // frame offsets with special meaning
    localparam int OFS_SYNC_END  = 3;   // first byte after sync: header length
    localparam int OFS_MID_LO    = 4;
    localparam int OFS_MID_HI    = 5;
    localparam int OFS_MSG_TYPE  = 6;
    localparam int OFS_PLEN_LO   = 8;
    localparam int OFS_PLEN_HI   = 9;
    localparam int OFS_FIXED_END = 10;  // first offset past the fixed header
    localparam int HDR_LEN_MIN   = 10;
    localparam int CRC_BYTES     = 4;
    localparam int MTYPE_LSB     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST  = 3'd0,
        CFG_SYNC_SECOND = 3'd1,
        CFG_SYNC_THIRD  = 3'd2,
        CFG_HDR_LEN     = 3'd3,
        CFG_CRC_POLY    = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_CRC_OK   = 3'd1,
        ST_CRC_BAD  = 3'd2,
        ST_BAD_HDR  = 3'd3,
        ST_TOO_LONG = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SEC_HEADER  = 2'd0,
        SEC_PAYLOAD = 2'd1,
        SEC_CRC     = 2'd2
    } section_t;

    typedef enum logic {
        PH_HUNT  = 1'b0,
        PH_FRAME = 1'b1
    } phase_t;

    // reflected crc-32, one byte, lsb first
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/binary_log_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// binary_log_frame_receiver_core
// sync hunt, header checks and crc-32 check of a binary log byte stream
// ----------------------------------------------------------------------------
//
//  channel  | direction | width (bits)        | content
//  ---------+-----------+---------------------+-------------------------------
//  s_axis   | in        | tdata 8             | one received byte
//  m_axis   | out       | tdata 40, tuser 5   | frame byte, offset, id, type,
//           |           | tlast 1             | section, status, last of frame
//  cfg      | in        | index 3, data 32    | register writes
//
//  one byte per clock sustained while m_axis is ready and no crc rebuild runs;
//  a frame byte reaches m_axis via the input register, then the result register
//  the sync bytes themselves give no output transfer
//  reset: hunting, sync window zero, registers at their defaults
//  after any cfg transfer s_axis is held off while the crc of the last two
//  window bytes is rebuilt with the current polynomial
//  m_axis back-pressure stalls frame bytes; hunt bytes keep flowing while a
//  result waits
// ----------------------------------------------------------------------------
`default_nettype none

module binary_log_frame_receiver_core
    import blfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // received bytes
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    // frame bytes out
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [39:0]               m_axis_tdata,   // [7:0] data_byte,
                                                      // [21:8] byte_index,
                                                      // [37:22] message_id,
                                                      // [39:38] message_type
    output logic [4:0]                m_axis_tuser,   // [1:0] section, [4:2] status
    output logic                      m_axis_tlast,   // is_last
    // register writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    // frame offsets up to MAX_FRAME_BYTES - 1, at least a byte wide so the
    // low payload length byte fits the frame length register
    localparam int OFS_W = $clog2(MAX_FRAME_BYTES);
    localparam int CNT_W = (OFS_W > BYTE_W) ? OFS_W : BYTE_W;
    localparam logic [TOT_W-1:0] LEN_LIMIT = TOT_W'(MAX_FRAME_BYTES - CRC_BYTES);

    // configuration registers
    logic [7:0]        sync_first_reg, sync_second_reg, sync_third_reg, hdr_len_reg;
    logic [CRC_W-1:0]  crc_poly_reg;

    // input register
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;

    // receiver state
    phase_t            phase_reg, phase_next;
    logic [23:0]       window_reg, window_next;
    logic [CRC_W-1:0]  crc1_reg, crc1_next;     // crc from zero over last byte
    logic [CRC_W-1:0]  crc2_reg, crc2_next;     // crc from zero over last two bytes
    logic [1:0]        rebuild_reg, rebuild_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  flen_reg, flen_next;
    logic [CRC_W-1:0]  run_crc_reg, run_crc_next;
    logic [CRC_W-1:0]  rx_crc_reg, rx_crc_next;
    logic [MID_W-1:0]  mid_reg, mid_next;
    logic [MTYPE_W-1:0] mtype_reg, mtype_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [39:0]       out_data_reg, out_data_next;
    logic [4:0]        out_user_reg, out_user_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              advance;
    logic              in_xfer;
    logic              cfg_xfer;

    assign cfg_ready     = 1'b1;
    assign cfg_xfer      = cfg_valid && cfg_ready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    // hunt bytes need no result slot
    assign advance       = in_valid_reg && ((phase_reg == PH_HUNT) || out_free);
    assign s_axis_tready = (!in_valid_reg || advance) && (rebuild_reg == 2'd0);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            sync_third_reg  <= SYNC_THIRD_RST;
            hdr_len_reg     <= HDR_LEN_RST;
            crc_poly_reg    <= CRC_POLY_RST;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                CFG_SYNC_THIRD:  sync_third_reg  <= cfg_data[7:0];
                CFG_HDR_LEN:     hdr_len_reg     <= cfg_data[7:0];
                CFG_CRC_POLY:    crc_poly_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            window_reg    <= '0;
            crc1_reg      <= '0;
            crc2_reg      <= '0;
            rebuild_reg   <= '0;
            cnt_reg       <= '0;
            flen_reg      <= '0;
            run_crc_reg   <= '0;
            rx_crc_reg    <= '0;
            mid_reg       <= '0;
            mtype_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            window_reg    <= window_next;
            crc1_reg      <= crc1_next;
            crc2_reg      <= crc2_next;
            rebuild_reg   <= rebuild_next;
            cnt_reg       <= cnt_next;
            flen_reg      <= flen_next;
            run_crc_reg   <= run_crc_next;
            rx_crc_reg    <= rx_crc_next;
            mid_reg       <= mid_next;
            mtype_reg     <= mtype_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    // per-byte logic
    always_comb
    begin
        logic [7:0]       b;
        logic [23:0]      shifted;
        logic [CRC_W-1:0] crc3;
        logic [CRC_W-1:0] crc_upd;
        logic [TOT_W-1:0] total;
        logic [1:0]       crc_ofs;
        logic [CRC_W-1:0] rx_full;
        logic             hdr_sec;
        section_t         sec;
        status_t          stat;
        logic             last;
        logic [MID_W-1:0] mid_out;
        logic [MTYPE_W-1:0] mtype_out;

        b         = in_byte_reg;
        shifted   = {window_reg[15:0], b};
        // sync crc = crc over the window as it will be after this byte
        crc3      = crc_byte(crc2_reg, b, crc_poly_reg);
        crc_upd   = crc_byte(run_crc_reg, b, crc_poly_reg);
        total     = TOT_W'(flen_reg[7:0]) + {1'b0, b, 8'h00} + TOT_W'(hdr_len_reg);
        crc_ofs   = 2'(cnt_reg - flen_reg);
        rx_full   = {b, rx_crc_reg[23:0]};
        hdr_sec   = TOT_W'(cnt_reg) < TOT_W'(hdr_len_reg);
        sec       = SEC_HEADER;
        stat      = ST_BUSY;
        last      = 1'b0;
        mid_out   = '0;
        mtype_out = '0;

        phase_next     = phase_reg;
        window_next    = window_reg;
        crc1_next      = crc1_reg;
        crc2_next      = crc2_reg;
        rebuild_next   = rebuild_reg;
        cnt_next       = cnt_reg;
        flen_next      = flen_reg;
        run_crc_next   = run_crc_reg;
        rx_crc_next    = rx_crc_reg;
        mid_next       = mid_reg;
        mtype_next     = mtype_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;

        // window crcs are rebuilt after a cfg write (polynomial may have changed):
        // first the last byte alone plus the older byte from zero, then the pair
        if (rebuild_reg == 2'd2)
        begin
            crc1_next    = crc_byte('0, window_reg[7:0], crc_poly_reg);
            crc2_next    = crc_byte('0, window_reg[15:8], crc_poly_reg);
            rebuild_next = 2'd1;
        end
        else if (rebuild_reg == 2'd1)
        begin
            crc2_next    = crc_byte(crc2_reg, window_reg[7:0], crc_poly_reg);
            rebuild_next = 2'd0;
        end

        if (advance)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    window_next = shifted;
                    crc1_next   = crc_byte('0, b, crc_poly_reg);
                    crc2_next   = crc_byte(crc1_reg, b, crc_poly_reg);
                    if (shifted == {sync_first_reg, sync_second_reg, sync_third_reg})
                    begin
                        phase_next   = PH_FRAME;
                        cnt_next     = CNT_W'(OFS_SYNC_END);
                        flen_next    = '0;
                        rx_crc_next  = '0;
                        mid_next     = '0;
                        mtype_next   = '0;
                        run_crc_next = crc3;
                    end
                end
                PH_FRAME:
                begin
                    priority if (cnt_reg < CNT_W'(OFS_FIXED_END))
                    begin
                        sec          = hdr_sec ? SEC_HEADER : SEC_PAYLOAD;
                        run_crc_next = crc_upd;
                        priority if (cnt_reg == CNT_W'(OFS_SYNC_END))
                        begin
                            if (b != hdr_len_reg || b < 8'(HDR_LEN_MIN))
                            begin
                                stat = ST_BAD_HDR;
                                last = 1'b1;
                            end
                        end
                        else if (cnt_reg == CNT_W'(OFS_MID_LO))
                        begin
                            mid_next = {8'h00, b};
                        end
                        else if (cnt_reg == CNT_W'(OFS_MID_HI))
                        begin
                            mid_next = {b, mid_reg[7:0]};
                        end
                        else if (cnt_reg == CNT_W'(OFS_MSG_TYPE))
                        begin
                            mtype_next = b[MTYPE_LSB +: MTYPE_W];
                        end
                        else if (cnt_reg == CNT_W'(OFS_PLEN_LO))
                        begin
                            flen_next = CNT_W'(b);
                        end
                        else if (cnt_reg == CNT_W'(OFS_PLEN_HI))
                        begin
                            if (total > LEN_LIMIT)
                            begin
                                stat = ST_TOO_LONG;
                                last = 1'b1;
                            end
                            else
                            begin
                                flen_next = CNT_W'(total);
                            end
                        end
                        else
                        begin
                        end
                    end
                    else if (cnt_reg < flen_reg)
                    begin
                        sec          = hdr_sec ? SEC_HEADER : SEC_PAYLOAD;
                        run_crc_next = crc_upd;
                    end
                    else
                    begin
                        // trailing crc, little-endian
                        sec = SEC_CRC;
                        unique case (crc_ofs)
                            2'd0: rx_crc_next = {rx_crc_reg[31:8], b};
                            2'd1: rx_crc_next = {rx_crc_reg[31:16], b, rx_crc_reg[7:0]};
                            2'd2: rx_crc_next = {rx_crc_reg[31:24], b, rx_crc_reg[15:0]};
                            2'd3:
                            begin
                                rx_crc_next = rx_full;
                                stat = (rx_full == run_crc_reg) ? ST_CRC_OK : ST_CRC_BAD;
                                last = 1'b1;
                            end
                            default: ;
                        endcase
                    end

                    if (cnt_reg >= CNT_W'(OFS_MID_HI))
                    begin
                        mid_out = mid_next;
                    end
                    if (cnt_reg >= CNT_W'(OFS_MSG_TYPE))
                    begin
                        mtype_out = mtype_next;
                    end

                    out_valid_next = 1'b1;
                    out_data_next  = {mtype_out, mid_out, IDX_W'(cnt_reg), b};
                    out_user_next  = {stat, sec};
                    out_last_next  = last;

                    if (last)
                    begin
                        // back to hunt as if three zero bytes had been seen
                        phase_next  = PH_HUNT;
                        window_next = '0;
                        crc1_next   = '0;
                        crc2_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end

        if (cfg_xfer)
        begin
            rebuild_next = 2'd2;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/blfr_checker.sv =====
// ----------------------------------------------------------------------------
// blfr_checker
// port-level checks of the frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module blfr_checker
    import blfr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic [4:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // last of frame exactly when a final status is reported
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[4:2] != ST_BUSY)))
        else $error("tlast and status disagree");

    // crc verdicts only on a trailing crc byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[4:2] == ST_CRC_OK || m_axis_tuser[4:2] == ST_CRC_BAD)
            |-> m_axis_tuser[1:0] == SEC_CRC)
        else $error("crc verdict outside the crc bytes");

    // header length failure is on the byte right after sync
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[4:2] == ST_BAD_HDR
            |-> m_axis_tdata[21:8] == 14'(OFS_SYNC_END))
        else $error("bad header length flagged at wrong offset");

endmodule

bind binary_log_frame_receiver_core blfr_checker u_blfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// regression bench for binary_log_frame_receiver_core: sync hunt, header
// length and frame length checks, crc-32 compare and byte pass-through,
// predicted byte by byte and checked on every output transfer
// ----------------------------------------------------------------------------

module tb;

    import blfr_pkg::*;

    localparam int FRAME_LIMIT            = MAX_FRAME_BYTES_DEF;
    localparam int SETTLE_CYCLES          = 6;        // two-stage pipe plus margin
    localparam int CYCLE_LIMIT            = 400000;
    localparam int RANDOM_BYTES_PER_PHASE = 90;

    // one frame byte as it should leave the block
    typedef struct {
        logic [7:0]  data;
        logic [13:0] offset;
        section_t    section;
        logic [15:0] msg_id;
        logic [1:0]  msg_kind;
        logic        last;
        status_t     status;
    } frame_byte_t;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tready = 1'b0;
    logic        cfg_valid     = 1'b0;
    cfg_index_t  cfg_index     = CFG_SYNC_FIRST;
    logic [31:0] cfg_data      = 32'h0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [39:0] m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_ready;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    binary_log_frame_receiver_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // deframer prediction: register copies and receiver state
    // ------------------------------------------------------------------------
    logic [7:0]  sync_a   = SYNC_FIRST_RST;
    logic [7:0]  sync_b   = SYNC_SECOND_RST;
    logic [7:0]  sync_c   = SYNC_THIRD_RST;
    logic [7:0]  hdr_len  = HDR_LEN_RST;
    logic [31:0] poly_reg = CRC_POLY_RST;

    logic [23:0] hunt_window = 24'h0;
    phase_t      rx_phase    = PH_HUNT;
    int          frame_offset = 0;
    int          frame_len    = 0;
    logic [31:0] crc_acc      = 32'h0;
    logic [31:0] crc_rx       = 32'h0;
    logic [15:0] id_hold      = 16'h0;
    logic [1:0]  kind_hold    = 2'b00;

    frame_byte_t frame_bytes_due[$];   // predicted frame bytes, oldest first
    logic [7:0]  frame_q[$];           // byte image of the frame being sent

    // bookkeeping
    int idle_pct  = 0;
    int stall_pct = 0;
    int errors    = 0;
    int rx_bytes  = 0;
    int reg_writes = 0;
    int n_checked = 0;
    int n_crc_ok  = 0;
    int n_crc_bad = 0;
    int n_bad_hdr = 0;
    int n_too_long = 0;
    int cycle_count = 0;

    // reflected crc-32, one input bit at a time
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b,
                                             input logic [31:0] poly);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = (c >> 1) ^ (fb ? poly : 32'h0);
        end
        return c;
    endfunction

    // advance the receiver by one accepted byte, queue the frame byte it gives
    function automatic void deframe_byte(input logic [7:0] b);
        frame_byte_t r;
        int          ofs;
        int          k;
        int          total;

        if (rx_phase == PH_HUNT)
        begin
            hunt_window = {hunt_window[15:0], b};
            if (hunt_window == {sync_a, sync_b, sync_c})
            begin
                rx_phase     = PH_FRAME;
                frame_offset = OFS_SYNC_END;
                frame_len    = 0;
                crc_rx       = 32'h0;
                id_hold      = 16'h0;
                kind_hold    = 2'b00;
                crc_acc      = crc_step(crc_step(crc_step(32'h0, sync_a, poly_reg),
                                                 sync_b, poly_reg), sync_c, poly_reg);
            end
            return;
        end

        ofs       = frame_offset;
        r.data    = b;
        r.offset  = ofs[13:0];
        r.section = SEC_HEADER;
        r.last    = 1'b0;
        r.status  = ST_BUSY;

        if (ofs < OFS_FIXED_END)
        begin
            r.section = (ofs < hdr_len) ? SEC_HEADER : SEC_PAYLOAD;
            crc_acc   = crc_step(crc_acc, b, poly_reg);
            case (ofs)
                OFS_SYNC_END:
                    if (b != hdr_len || b < HDR_LEN_MIN)
                    begin
                        r.status = ST_BAD_HDR;
                        r.last   = 1'b1;
                    end
                OFS_MID_LO:   id_hold = {8'h00, b};
                OFS_MID_HI:   id_hold[15:8] = b;
                OFS_MSG_TYPE: kind_hold = b[MTYPE_LSB +: 2];
                OFS_PLEN_LO:  frame_len = b;
                OFS_PLEN_HI:
                begin
                    // full-width int sum, so the largest length cannot wrap past the limit
                    total = (frame_len & 8'hFF) + (int'(b) << 8) + hdr_len;
                    if (total > FRAME_LIMIT - CRC_BYTES)
                    begin
                        r.status = ST_TOO_LONG;
                        r.last   = 1'b1;
                    end
                    else
                        frame_len = total;
                end
                default: ;
            endcase
        end
        else if (ofs < frame_len)
        begin
            r.section = (ofs < hdr_len) ? SEC_HEADER : SEC_PAYLOAD;
            crc_acc   = crc_step(crc_acc, b, poly_reg);
        end
        else
        begin
            // trailing crc, little-endian
            k         = (ofs - frame_len) & 3;
            r.section = SEC_CRC;
            crc_rx    = crc_rx | ({24'h0, b} << (8 * k));
            if (k == CRC_BYTES - 1)
            begin
                r.status = (crc_rx == crc_acc) ? ST_CRC_OK : ST_CRC_BAD;
                r.last   = 1'b1;
            end
        end

        r.msg_id   = (ofs >= OFS_MID_HI) ? id_hold : 16'h0;
        r.msg_kind = (ofs >= OFS_MSG_TYPE) ? kind_hold : 2'b00;
        frame_bytes_due.insert(frame_bytes_due.size(), r);

        if (r.last)
        begin
            // end or abort: back to hunt with an empty window
            rx_phase    = PH_HUNT;
            hunt_window = 24'h0;
        end
        else
            frame_offset = ofs + 1;
    endfunction

    // ------------------------------------------------------------------------
    // output side: random back-pressure and the per-transfer check
    // ------------------------------------------------------------------------
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d frame bytes still due",
                     cycle_count, frame_bytes_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // each output transfer against the oldest predicted frame byte
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                $display("%0t: unexpected output transfer, expected none, actual data %0h offset %0d",
                         $time, m_axis_tdata[7:0], m_axis_tdata[21:8]);
                errors++;
            end
            else
            begin
                want = frame_bytes_due.pop_front();
                check_field("data_byte",    want.data,     m_axis_tdata[7:0]);
                check_field("byte_index",   want.offset,   m_axis_tdata[21:8]);
                check_field("message_id",   want.msg_id,   m_axis_tdata[37:22]);
                check_field("message_type", want.msg_kind, m_axis_tdata[39:38]);
                check_field("section",      want.section,  m_axis_tuser[1:0]);
                check_field("status",       want.status,   m_axis_tuser[4:2]);
                check_field("is_last",      want.last,     m_axis_tlast);
                n_checked++;
            end
            case (m_axis_tuser[4:2])
                ST_CRC_OK:   n_crc_ok++;
                ST_CRC_BAD:  n_crc_bad++;
                ST_BAD_HDR:  n_bad_hdr++;
                ST_TOO_LONG: n_too_long++;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // one byte transfer; entered and left at a falling edge, valid stays high
    // between back-to-back bytes
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready))
            @(posedge clk);
        deframe_byte(b);
        rx_bytes++;
        @(negedge clk);
    endtask

    task automatic push_frame(input int count);
        for (int i = 0; i < count && i < frame_q.size(); i++)
            push_byte(frame_q[i]);
    endtask

    // stop sending, let every predicted byte come out, then let the pipe empty
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (frame_bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(input cfg_index_t which, input logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        case (which)
            CFG_SYNC_FIRST:  sync_a   = value[7:0];
            CFG_SYNC_SECOND: sync_b   = value[7:0];
            CFG_SYNC_THIRD:  sync_c   = value[7:0];
            CFG_HDR_LEN:     hdr_len  = value[7:0];
            CFG_CRC_POLY:    poly_reg = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // byte image of a frame under the current registers; a frame that will be
    // rejected as too long stops after its length bytes
    task automatic make_frame(input int plen, input logic [7:0] hl_byte,
                              input logic [15:0] mid, input logic [7:0] kind_byte,
                              input logic [31:0] crc_flip);
        int          total;
        logic [31:0] crc;
        logic [7:0]  b;
        frame_q.delete();
        crc   = 32'h0;
        total = hdr_len + plen;
        for (int i = 0; i < total; i++)
        begin
            case (i)
                0:            b = sync_a;
                1:            b = sync_b;
                2:            b = sync_c;
                OFS_SYNC_END: b = hl_byte;
                OFS_MID_LO:   b = mid[7:0];
                OFS_MID_HI:   b = mid[15:8];
                OFS_MSG_TYPE: b = kind_byte;
                OFS_PLEN_LO:  b = plen[7:0];
                OFS_PLEN_HI:  b = plen[15:8];
                default:      b = 8'($urandom_range(0, 255));
            endcase
            frame_q.insert(frame_q.size(), b);
            crc = crc_step(crc, b, poly_reg);
            if (i == OFS_PLEN_HI && total > FRAME_LIMIT - CRC_BYTES)
                return;
        end
        crc = crc ^ crc_flip;
        for (int k = 0; k < CRC_BYTES; k++)
            frame_q.insert(frame_q.size(), crc[8 * k +: 8]);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset registers: plain frames, crc mismatch, sync overlap, window clear
    task automatic test_default_frames();
        make_frame(0, hdr_len, 16'h0000, 8'h00, 32'h0);
        push_frame(frame_q.size());
        make_frame(6, hdr_len, 16'hFFFF, 8'hFF, 32'h0);
        push_frame(frame_q.size());
        make_frame(3, hdr_len, 16'h1234, 8'h20, 32'h8000_0001);
        push_frame(frame_q.size());
        // a repeated first sync byte still lines up on the real pattern
        push_byte(sync_a);
        make_frame(2, hdr_len, 16'hA55A, 8'h30, 32'h0);
        push_frame(frame_q.size());
        // header-length abort on the first sync byte: the window restarts
        // empty, so the two bytes after it must not complete a sync
        make_frame(0, sync_a, 16'h0, 8'h0, 32'h0);
        push_frame(OFS_SYNC_END + 1);
        push_byte(sync_b);
        push_byte(sync_c);
        // length bytes equal to the first two sync bytes, too long, then the
        // third sync byte alone
        make_frame({sync_b, sync_a}, hdr_len, 16'h0101, 8'h10, 32'h0);
        push_frame(frame_q.size());
        push_byte(sync_c);
        make_frame(1, hdr_len, 16'h8001, 8'hEF, 32'h0);
        push_frame(frame_q.size());
    endtask

    // header length byte wrong or out of range, shortest and longest header
    task automatic test_header_length();
        make_frame(2, hdr_len + 8'd1, 16'h0, 8'h0, 32'h0);
        push_frame(frame_q.size());
        make_frame(2, 8'h00, 16'h0, 8'h0, 32'h0);
        push_frame(frame_q.size());
        make_frame(2, 8'hFF, 16'h0, 8'h0, 32'h0);
        push_frame(frame_q.size());
        make_frame(2, 8'(HDR_LEN_MIN - 1), 16'h0, 8'h0, 32'h0);
        push_frame(frame_q.size());

        write_reg(CFG_HDR_LEN, HDR_LEN_MIN);
        // no payload: the crc follows the fixed header directly
        make_frame(0, hdr_len, 16'hC0DE, 8'h10, 32'h0);
        push_frame(frame_q.size());
        make_frame(2, hdr_len, 16'h0BAD, 8'h20, 32'h0);
        push_frame(frame_q.size());
        make_frame(2, 8'(HDR_LEN_MIN - 1), 16'h0, 8'h0, 32'h0);
        push_frame(frame_q.size());

        write_reg(CFG_HDR_LEN, 8'hFF);
        make_frame(3, hdr_len, 16'h7FFE, 8'h30, 32'h0);
        push_frame(frame_q.size());
    endtask

    // frame length limit: largest length field, one over the limit
    task automatic test_length_limit();
        make_frame(16'hFFFF, hdr_len, 16'h0, 8'h0, 32'h0);
        push_frame(frame_q.size());
        write_reg(CFG_HDR_LEN, HDR_LEN_RST);
        make_frame(FRAME_LIMIT - CRC_BYTES - hdr_len + 1, hdr_len, 16'h0, 8'h0, 32'h0);
        push_frame(frame_q.size());
    endtask

    // sync and polynomial at their extremes, then back to defaults
    task automatic test_register_extremes();
        write_reg(CFG_SYNC_FIRST, 32'h00);
        write_reg(CFG_SYNC_SECOND, 32'h00);
        write_reg(CFG_SYNC_THIRD, 32'h00);
        // an all-zero pattern matches on an emptied window almost at once
        make_frame(2, hdr_len, 16'h0000, 8'h00, 32'h0);
        push_frame(frame_q.size());
        make_frame(4, hdr_len, 16'h5A5A, 8'h20, 32'h0);
        push_frame(frame_q.size());

        write_reg(CFG_SYNC_FIRST, 32'hFF);
        write_reg(CFG_SYNC_SECOND, 32'hFF);
        write_reg(CFG_SYNC_THIRD, 32'hFF);
        push_byte(8'hFF);
        make_frame(3, hdr_len, 16'hFFFF, 8'hFF, 32'h0);
        push_frame(frame_q.size());

        write_reg(CFG_CRC_POLY, 32'h0000_0000);
        make_frame(5, hdr_len, 16'h1111, 8'h10, 32'h0);
        push_frame(frame_q.size());
        write_reg(CFG_CRC_POLY, 32'hFFFF_FFFF);
        make_frame(5, hdr_len, 16'h2222, 8'h20, 32'h0);
        push_frame(frame_q.size());
        make_frame(5, hdr_len, 16'h3333, 8'h30, 32'h0000_0100);
        push_frame(frame_q.size());

        write_reg(CFG_SYNC_FIRST, SYNC_FIRST_RST);
        write_reg(CFG_SYNC_SECOND, SYNC_SECOND_RST);
        write_reg(CFG_SYNC_THIRD, SYNC_THIRD_RST);
        write_reg(CFG_CRC_POLY, $urandom());
        make_frame(4, hdr_len, 16'h4444, 8'h00, 32'h0);
        push_frame(frame_q.size());
        write_reg(CFG_CRC_POLY, CRC_POLY_RST);
    endtask

    // mostly good frames with random content, some broken ones and line noise,
    // over four phases of input idling and output stalls
    task automatic test_random_traffic();
        int          mark;
        int          pick;
        int          plen;
        int          n;
        logic [31:0] flip;
        logic [7:0]  bad_hl;

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 62; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 8;  stall_pct = 8;  end
            endcase
            mark = rx_bytes;
            while (rx_bytes - mark < RANDOM_BYTES_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
                                                   : $urandom_range(0, 24);
                if (pick < 5)
                begin
                    // new register set between frames
                    write_reg(CFG_SYNC_FIRST, $urandom_range(0, 255));
                    write_reg(CFG_SYNC_SECOND, $urandom_range(0, 255));
                    write_reg(CFG_SYNC_THIRD, $urandom_range(0, 255));
                    write_reg(CFG_HDR_LEN, ($urandom_range(0, 9) == 0)
                                           ? $urandom_range(HDR_LEN_MIN, 255)
                                           : $urandom_range(HDR_LEN_MIN, 40));
                    write_reg(CFG_CRC_POLY, $urandom_range(0, 1) ? CRC_POLY_RST : $urandom());
                end
                else if (pick < 70)
                begin
                    make_frame(plen, hdr_len, 16'($urandom_range(0, 65535)),
                               8'($urandom_range(0, 255)), 32'h0);
                    push_frame(frame_q.size());
                end
                else if (pick < 78)
                begin
                    flip = $urandom();
                    if (flip == 32'h0)
                        flip = 32'h1;
                    make_frame(plen, hdr_len, 16'($urandom_range(0, 65535)),
                               8'($urandom_range(0, 255)), flip);
                    push_frame(frame_q.size());
                end
                else if (pick < 83)
                begin
                    bad_hl = 8'($urandom_range(0, 255));
                    if (bad_hl == hdr_len)
                        bad_hl = ~bad_hl;
                    make_frame(plen, bad_hl, 16'($urandom()), 8'($urandom()), 32'h0);
                    push_frame($urandom_range(OFS_SYNC_END + 1, frame_q.size()));
                end
                else if (pick < 88)
                begin
                    make_frame($urandom_range(FRAME_LIMIT - CRC_BYTES - hdr_len + 1, 65535),
                               hdr_len, 16'($urandom()), 8'($urandom()), 32'h0);
                    push_frame(frame_q.size());
                end
                else if (pick < 93)
                begin
                    // frame cut short; the next bytes are taken as its remainder
                    make_frame($urandom_range(0, 12), hdr_len, 16'($urandom()),
                               8'($urandom()), 32'h0);
                    push_frame($urandom_range(OFS_SYNC_END + 1, frame_q.size() - 1));
                end
                else
                begin
                    // line noise, partly made of sync bytes
                    n = $urandom_range(1, 12);
                    for (int i = 0; i < n; i++)
                    begin
                        case ($urandom_range(0, 5))
                            0:       push_byte(sync_a);
                            1:       push_byte(sync_b);
                            2:       push_byte(sync_c);
                            default: push_byte(8'($urandom_range(0, 255)));
                        endcase
                    end
                end
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_frames();
        test_header_length();
        test_length_limit();
        test_register_extremes();
        test_random_traffic();
        wait_drained();

        $display("%0d bytes sent, %0d frame byte transfers checked, %0d register writes",
                 rx_bytes, n_checked, reg_writes);
        $display("frames ended: %0d crc good, %0d crc bad, %0d header aborts, %0d length aborts",
                 n_crc_ok, n_crc_bad, n_bad_hdr, n_too_long);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/blfr_pkg.sv
hw/rtl/binary_log_frame_receiver_core.sv
hw/rtl/blfr_checker.sv
bench/tb.sv
